>>> rtl/wbps_pkg.sv
// shared constants for the wildcard byte pattern scan block
package wbps_pkg;

   localparam int DEF_MAX_PATTERN_BYTES = 16;

   localparam int BYTE_W       = 8;
   localparam int POS_W        = 32;
   localparam int ADDR_W       = 64;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int CARE_W       = 16;
   localparam int LEN_W        = 5;
   localparam int PATTERN_W    = 128;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = POS_W + ADDR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR    = 3'd4;

   localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

endpackage

>>> rtl/wildcard_byte_pattern_scan.sv
// top level: streaming wildcard byte signature search with shift-and matching
//
//  channel | direction | tdata (low bit up)                   | side bands
//  --------+-----------+--------------------------------------+----------------------
//  req_    | in        | data_byte[7:0]                       | tlast = last_byte
//  rsp_    | out       | match_offset[31:0], match_address    | tuser = found
//  csr_    | in        | csr_wdata: register value            | csr_we, csr_index
//
//  one byte is taken per cycle while req_tready is high; the compare against all
//  pattern bytes and the partial-match shift finish in the cycle of the transaction
//  a result is registered into the output register, or into the skid slot if rsp_ stalls
//  an output register plus one skid slot hold results; req_tready falls only
//  while both are full
//  reset clears the scan state and result valid flags and loads the register reset values
module wildcard_byte_pattern_scan #(
   parameter int MaxPatternBytes = wbps_pkg::DEF_MAX_PATTERN_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wbps_pkg::REQ_TDATA_W-1:0]   req_tdata,   // data_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wbps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // match_offset, match_address
   output logic [0:0]                         rsp_tuser,   // found
   input  logic                               csr_we,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wbps_pkg::*;

   localparam int P      = MaxPatternBytes;
   localparam int LIDX_W = (P > 1) ? $clog2(P) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(P);

   // configuration registers
   logic [63:0]       pat_low_ff, pat_high_ff, base_ff;
   logic [CARE_W-1:0] care_ff;
   logic [LEN_W-1:0]  len_ff;

   // scan state
   logic [P-1:0]      pmv_ff, pmv_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              reported_ff, reported_in;

   // output register and skid slot
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;
   logic [POS_W-1:0]  out_off_ff, out_off_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              skid_found_ff, skid_found_in;
   logic [POS_W-1:0]  skid_off_ff, skid_off_in;
   logic [ADDR_W-1:0] skid_addr_ff, skid_addr_in;

   logic                 accept;
   logic [BYTE_W-1:0]    data_byte;
   logic [PATTERN_W-1:0] pattern;
   logic [LEN_W-1:0]     len_eff;
   logic [LIDX_W-1:0]    len_idx;
   logic [P-1:0]         hit;
   logic [P-1:0]         pmv_step;
   logic                 match_done;
   logic [POS_W-1:0]     match_off;
   logic                 new_valid;
   logic                 new_found;
   logic [POS_W-1:0]     new_off;
   logic [ADDR_W-1:0]    new_addr;

   assign accept    = req_tvalid & req_tready;
   assign data_byte = req_tdata[BYTE_W-1:0];
   assign pattern   = {pat_high_ff, pat_low_ff};

   always_comb begin
      priority if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = len_ff;
      end
   end

   assign len_idx = LIDX_W'(len_eff - LEN_W'(1));

   // per-position compare, wildcard where care bit is clear, off beyond length
   for (genvar i = 0; i < P; i++) begin : g_cmp
      assign hit[i] = (LEN_W'(i) < len_eff) &&
                      (!care_ff[i] || (pattern[8*i +: 8] == data_byte));
   end

   assign pmv_step   = ((pmv_ff << 1) | P'(1)) & hit;
   assign match_done = pmv_step[len_idx];
   assign match_off  = pos_ff - POS_W'(len_eff - LEN_W'(1));

   assign new_valid = accept && !reported_ff && (match_done || req_tlast);
   assign new_found = match_done;
   assign new_off   = match_done ? match_off : '0;
   assign new_addr  = match_done ? (base_ff + ADDR_W'(match_off)) : '0;

   always_comb begin
      pmv_in      = pmv_ff;
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (!reported_ff) begin
            pmv_in      = pmv_step;
            pos_in      = pos_ff + POS_W'(1);
            reported_in = match_done;
         end
         // end of range starts a fresh scan
         if (req_tlast) begin
            pmv_in      = '0;
            pos_in      = '0;
            reported_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_off_in    = out_off_ff;
      out_addr_in   = out_addr_ff;
      skid_valid_in = skid_valid_ff;
      skid_found_in = skid_found_ff;
      skid_off_in   = skid_off_ff;
      skid_addr_in  = skid_addr_ff;
      if (out_valid_ff && !rsp_tready) begin
         if (new_valid) begin
            skid_valid_in = 1'b1;
            skid_found_in = new_found;
            skid_off_in   = new_off;
            skid_addr_in  = new_addr;
         end
      end else if (skid_valid_ff) begin
         // no transaction on req_ while the skid slot is full
         out_valid_in  = 1'b1;
         out_found_in  = skid_found_ff;
         out_off_in    = skid_off_ff;
         out_addr_in   = skid_addr_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = new_valid;
         out_found_in = new_found;
         out_off_in   = new_off;
         out_addr_in  = new_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= CARE_RESET;
         len_ff      <= LEN_RESET;
         base_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_CARE_MASK:    care_ff     <= csr_wdata[CARE_W-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_wdata[LEN_W-1:0];
            CSR_BASE_ADDR:    base_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmv_ff        <= '0;
         pos_ff        <= '0;
         reported_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pmv_ff        <= pmv_in;
         pos_ff        <= pos_in;
         reported_ff   <= reported_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff  <= out_found_in;
      out_off_ff    <= out_off_in;
      out_addr_ff   <= out_addr_in;
      skid_found_ff <= skid_found_in;
      skid_off_ff   <= skid_off_in;
      skid_addr_ff  <= skid_addr_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_addr_ff, out_off_ff};
   assign rsp_tuser  = out_found_ff;

endmodule

>>> rtl/wbps_checker.sv
// port-level checks for the wildcard byte pattern scan, bound to the top level
module wbps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wbps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [0:0]                        rsp_tuser
);
   import wbps_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp dropped while stalled");

   // not-found results carry zero offset and address
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("not-found result with nonzero payload");

   // nothing to report right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a result never appears without a req transaction before it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without a req transaction");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> test/wildcard_byte_pattern_scan_tb.sv
// self-checking testbench for the wildcard byte pattern scan block
`timescale 1ns / 100ps

module wildcard_byte_pattern_scan_tb;
   import wbps_pkg::*;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  offset;
      logic [ADDR_W-1:0] address;
   } scan_result_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  wdata;
      logic [BYTE_W-1:0]      data;
      bit                     last;
      bit                     typed;
      bit                     typed_has;
      scan_result_type        typed_res;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // shadow registers and scan state of the predictor
   logic [63:0]       pat_lo_q;
   logic [63:0]       pat_hi_q;
   logic [CARE_W-1:0] care_q;
   logic [LEN_W-1:0]  len_q;
   logic [63:0]       base_q;
   logic [15:0]       live_q;
   logic [POS_W-1:0]  pos_q;
   bit                hit_seen_q;

   scan_result_type awaited_results[$];
   stim_row_type    directed_rows[$];
   int              mismatches = 0;
   int              scanned_items = 0;
   bit              hold_off_pending = 1'b0;
   bit              calm_tail = 1'b0;

   wildcard_byte_pattern_scan dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic int eff_len();
      int n;
      n = len_q;
      if (n < 1) n = 1;
      if (n > DEF_MAX_PATTERN_BYTES) n = DEF_MAX_PATTERN_BYTES;
      return n;
   endfunction

   task automatic clear_scan_state();
      live_q = '0;
      pos_q = '0;
      hit_seen_q = 1'b0;
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      case (idx)
         CSR_PATTERN_LOW:  pat_lo_q = v;
         CSR_PATTERN_HIGH: pat_hi_q = v;
         CSR_CARE_MASK:    care_q = v[CARE_W-1:0];
         CSR_PATTERN_LEN:  len_q = v[LEN_W-1:0];
         CSR_BASE_ADDR:    base_q = v;
         default: ;
      endcase
   endtask

   // shift-and step over one byte of the range
   task automatic predict_scan(input logic [7:0] b, input bit last, output bit has,
                               output scan_result_type res);
      int n;
      logic [15:0] accept;
      logic [127:0] pat;
      logic [POS_W-1:0] off;
      has = 1'b0;
      res = '0;
      if (!hit_seen_q) begin
         n = eff_len();
         pat = {pat_hi_q, pat_lo_q};
         accept = '0;
         for (int i = 0; i < n; i++) begin
            if (!care_q[i] || pat[8*i +: 8] == b) accept[i] = 1'b1;
         end
         live_q = ((live_q << 1) | 16'h1) & accept;
         if (live_q[n-1]) begin
            off = pos_q - POS_W'(n - 1);
            res.found = 1'b1;
            res.offset = off;
            res.address = base_q + {32'h0, off};
            hit_seen_q = 1'b1;
            has = 1'b1;
         end else if (last) begin
            has = 1'b1;
         end
         pos_q = pos_q + 1'b1;
      end
      if (last) clear_scan_state();
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                            input bit typed_has, input scan_result_type typed_res);
      bit has;
      scan_result_type res;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      predict_scan(b, last, has, res);
      if (typed) begin
         has = typed_has;
         res = typed_res;
      end
      if (has) awaited_results.push_back(res);
      scanned_items++;
      @(negedge clock);
   endtask

   // registers change only once the block has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      apply_csr(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic scan_result_type mk_res(input logic f, input logic [31:0] o,
                                              input logic [63:0] a);
      scan_result_type r;
      r.found = f;
      r.offset = o;
      r.address = a;
      return r;
   endfunction

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      stim_row_type r;
      r = '{kind: ROW_CSR, idx: idx, wdata: v, data: '0, last: 1'b0, typed: 1'b0,
            typed_has: 1'b0, typed_res: '0};
      directed_rows.push_back(r);
   endtask

   task automatic add_byte(input logic [7:0] b, input bit last, input bit typed,
                           input bit has, input scan_result_type res);
      stim_row_type r;
      r = '{kind: ROW_BYTE, idx: '0, wdata: '0, data: b, last: last, typed: typed,
            typed_has: has, typed_res: res};
      directed_rows.push_back(r);
   endtask

   task automatic build_directed();
      // reset pattern is a single zero byte, all compared
      add_byte(8'h00, 1'b0, 1'b1, 1'b1, mk_res(1'b1, 32'h0, 64'h0));
      add_byte(8'hFF, 1'b1, 1'b1, 1'b0, '0);
      add_byte(8'hFF, 1'b1, 1'b1, 1'b1, mk_res(1'b0, 32'h0, 64'h0));
      // zero length acts as one, match on the last byte, top address
      add_csr(CSR_BASE_ADDR, '1);
      add_csr(CSR_PATTERN_LOW, 64'hFF);
      add_csr(CSR_PATTERN_LEN, 64'h0);
      add_byte(8'hFF, 1'b1, 1'b1, 1'b1, mk_res(1'b1, 32'h0, '1));
      add_byte(8'h00, 1'b1, 1'b1, 1'b1, mk_res(1'b0, 32'h0, 64'h0));
      // oversized length saturates, all wildcards
      add_csr(CSR_PATTERN_LEN, 64'h1F);
      add_csr(CSR_CARE_MASK, 64'h0);
      add_csr(CSR_BASE_ADDR, 64'h1);
      add_csr(CSR_PATTERN_HIGH, '1);
      for (int k = 0; k < 15; k++) add_byte(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      add_byte(8'($urandom), 1'b1, 1'b1, 1'b1, mk_res(1'b1, 32'h0, 64'h1));
      // writes to indexes past the register file are dropped
      for (int k = CSR_BASE_ADDR + 1; k < 2**CSR_IDX_W; k++)
         add_csr(CSR_IDX_W'(k), {$urandom, $urandom});
      add_csr(CSR_CARE_MASK, 64'h1);
      add_csr(CSR_PATTERN_LEN, 64'h2);
      add_csr(CSR_PATTERN_LOW, 64'hA5);
      add_byte(8'hA5, 1'b0, 1'b0, 1'b0, '0);
      add_byte(8'hA5, 1'b0, 1'b0, 1'b0, '0);
      add_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
      add_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
   endtask

   task automatic random_setup(input bit pressure);
      logic [63:0] v;
      int r;
      r = $urandom_range(0, 9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      write_reg(CSR_PATTERN_LOW, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      write_reg(CSR_PATTERN_HIGH, v);
      r = $urandom_range(0, 19);
      v = {$urandom, $urandom};
      if (pressure || r == 0) v[15:0] = '0;
      else if (r < 7) v[15:0] = '1;
      else v[15:0] = 16'($urandom | $urandom);
      if ($urandom_range(0, 3) != 0) v[63:16] = '0;
      write_reg(CSR_CARE_MASK, v);
      r = $urandom_range(0, 19);
      v = {$urandom, $urandom};
      if (pressure) v[4:0] = 5'd1;
      else if (r < 14) v[4:0] = 5'($urandom_range(1, 4));
      else if (r < 17) v[4:0] = 5'($urandom_range(5, 16));
      else if (r < 18) v[4:0] = 5'd0;
      else v[4:0] = 5'($urandom_range(17, 31));
      if ($urandom_range(0, 3) != 0) v[63:5] = '0;
      write_reg(CSR_PATTERN_LEN, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      write_reg(CSR_BASE_ADDR, v);
   endtask

   // mode 0 is noise, 1 carries the pattern, 2 carries it with one byte spoiled
   task automatic scan_range(input int nbytes, input int mode);
      int n;
      int at;
      int spoil;
      int j;
      logic [7:0] b;
      logic [127:0] pat;
      n = eff_len();
      pat = {pat_hi_q, pat_lo_q};
      if (nbytes < n) mode = 0;
      at = (nbytes >= n) ? $urandom_range(0, nbytes - n) : 0;
      spoil = $urandom_range(0, n - 1);
      for (int k = 0; k < nbytes; k++) begin
         if (mode != 0 && k >= at && k < at + n) begin
            j = k - at;
            b = care_q[j] ? pat[8*j +: 8] : 8'($urandom);
            if (mode == 2 && j == spoil) b = pat[8*j +: 8] ^ (8'h1 << $urandom_range(0, 7));
         end else if ($urandom_range(0, 1) == 0) begin
            b = 8'($urandom);
         end else begin
            b = pat[8*$urandom_range(0, n - 1) +: 8];
         end
         send_byte(b, k == nbytes - 1, 1'b0, 1'b0, '0);
      end
   endtask

   // receiver side: random stalls plus one long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
         end else if (!calm_tail && $urandom_range(0, 6) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch("unexpected result", rsp_tdata[63:0], 64'h0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser[0] !== want.found)
               flag_mismatch("found", 64'(rsp_tuser[0]), 64'(want.found));
            if (rsp_tdata[POS_W-1:0] !== want.offset)
               flag_mismatch("match_offset", 64'(rsp_tdata[POS_W-1:0]), 64'(want.offset));
            if (rsp_tdata[POS_W +: ADDR_W] !== want.address)
               flag_mismatch("match_address", rsp_tdata[POS_W +: ADDR_W], want.address);
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      int phase;
      int mode;
      pat_lo_q = '0;
      pat_hi_q = '0;
      care_q = CARE_RESET;
      len_q = LEN_RESET;
      base_q = '0;
      clear_scan_state();
      build_directed();
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].idx, directed_rows[i].wdata);
         else
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].typed_has, directed_rows[i].typed_res);
      end

      phase = 0;
      while (scanned_items < 1400) begin
         if (scanned_items >= 1200) calm_tail = 1'b1;
         random_setup(phase == 3);
         if (phase == 3) hold_off_pending = 1'b1;
         repeat ((phase == 3) ? 40 : $urandom_range(3, 8)) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 1 : (mode < 8) ? 2 : 0;
            scan_range(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 20), mode);
         end
         phase++;
      end

      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
